// File: design/assert_macros.svh
// Assertion macros shared by the hash set table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HSM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hash set table: assertion failed");

// Checked on every clock edge, reset included.
`define HSM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hash set table: assertion failed");

`endif

// File: design/hsm_pkg.sv
// Shared types and constants of the hash set membership table.
package hsm_pkg;

   localparam int KEY_W = 31;
   localparam int OP_W  = 2;

   // Opcodes; the unused code behaves as a query.
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic was_present;
      logic dropped;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } slot_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture request beat
      logic mul;    // quotient estimate
      logic mulb;   // quotient times bucket count
      logic modr;   // remainder and correction
      logic rd;     // bucket row read
      logic upd;    // compare, write back, load result
      logic clr;    // clear one row
   } cmd_type;

   typedef struct packed {
      logic clr_last;
   } status_type;

endpackage

// File: design/hsm_ctrl.sv
// Sequencer of the hash set table: clear pass, per-request steps, result valid.
`include "assert_macros.svh"

module hsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  hsm_pkg::status_type status,
   output hsm_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_MULB  = 7'b0001000,
      S_MOD   = 7'b0010000,
      S_READ  = 7'b0100000,
      S_UPD   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.mulb = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.modr = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            // hold until the result register can take the beat
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.upd  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.upd) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `HSM_ASSERT(a_upd_slot_free, clock, reset, cmd.upd |-> (!rsp_valid_ff || rsp_ready))
   `HSM_ASSERT(a_accept_starts, clock, reset, (req_valid && req_ready) |=> (state_ff == S_MUL))
   `HSM_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid)

endmodule

// File: design/hsm_datapath.sv
// Hash set datapath: key modulo, bucket row memory, way compare, result register.
`include "assert_macros.svh"

module hsm_datapath #(
   parameter int unsigned BUCKETS = 769,
   parameter int unsigned WAYS    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  hsm_pkg::req_type    req_data,
   input  hsm_pkg::cmd_type    cmd,
   output hsm_pkg::status_type status,
   output hsm_pkg::rsp_type    rsp_data
);

   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int BW    = $clog2(BUCKETS + 1);
   localparam int KW    = hsm_pkg::KEY_W;
   // floor(2^32 / BUCKETS): quotient estimate is exact or one low
   localparam logic [31:0]   RECIP    = 32'((64'd1 << 32) / BUCKETS);
   localparam logic [BW-1:0] BKT      = BW'(BUCKETS);
   localparam logic [KW-1:0] BKT_K    = KW'(BUCKETS);
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BUCKETS - 1);

   typedef hsm_pkg::slot_type [WAYS-1:0] row_type;

   row_type                 row_mem [BUCKETS];
   row_type                 rd_row_ff;
   logic [KW-1:0]           key_ff;
   logic [hsm_pkg::OP_W-1:0] op_ff;
   logic [KW-1:0]           q_ff;
   logic [KW-1:0]           qb_ff;
   logic [IDX_W-1:0]        row_ff;
   logic [IDX_W-1:0]        clr_cnt_ff;
   hsm_pkg::rsp_type        rsp_ff;

   logic [KW+31:0]          qprod;
   logic [KW+BW-1:0]        bprod;
   logic [KW-1:0]           rem;
   logic [KW-1:0]           rem_fix;

   logic [WAYS-1:0]         hit;
   logic [WAYS-1:0]         hit_one;
   logic [WAYS-1:0]         free_one;
   logic                    found_hit;
   logic                    found_free;
   row_type                 new_row;
   hsm_pkg::rsp_type        rsp_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   row_type                 wr_row;

   // bucket = key - floor(key * RECIP / 2^32) * BUCKETS, one fix-up
   assign qprod   = key_ff * RECIP;
   assign bprod   = q_ff * BKT;
   assign rem     = key_ff - qb_ff;
   assign rem_fix = (rem >= BKT_K) ? (rem - BKT_K) : rem;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data.key;
         op_ff  <= req_data.opcode;
      end
      if (cmd.mul) begin
         q_ff <= qprod[KW+31:32];
      end
      if (cmd.mulb) begin
         qb_ff <= bprod[KW-1:0];
      end
      if (cmd.modr) begin
         row_ff <= rem_fix[IDX_W-1:0];
      end
   end

   always_comb begin
      found_hit  = 1'b0;
      found_free = 1'b0;
      hit        = '0;
      hit_one    = '0;
      free_one   = '0;
      new_row    = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = rd_row_ff[w].valid && (rd_row_ff[w].key == key_ff);
      end
      for (int w = 0; w < WAYS; w++) begin
         if (hit[w] && !found_hit) begin
            hit_one[w] = 1'b1;
            found_hit  = 1'b1;
         end
         if (!rd_row_ff[w].valid && !found_free) begin
            free_one[w] = 1'b1;
            found_free  = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if ((op_ff == hsm_pkg::OP_ADD) && !found_hit && free_one[w]) begin
            new_row[w].valid = 1'b1;
            new_row[w].key   = key_ff;
         end
         if ((op_ff == hsm_pkg::OP_REMOVE) && hit_one[w]) begin
            new_row[w].valid = 1'b0;
         end
      end
      rsp_in.was_present = found_hit;
      rsp_in.dropped     = (op_ff == hsm_pkg::OP_ADD) && !found_hit && !found_free;
   end

   assign wr_en   = cmd.clr || cmd.upd;
   assign wr_addr = cmd.clr ? clr_cnt_ff : row_ff;
   assign wr_row  = cmd.clr ? row_type'('0) : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (cmd.rd) begin
         rd_row_ff <= row_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.clr_last = (clr_cnt_ff == LAST_ROW);
   assign rsp_data        = rsp_ff;

   `HSM_ASSERT(a_row_in_range, clock, reset, cmd.rd |-> (row_ff <= LAST_ROW))
   `HSM_ASSERT(a_single_hit, clock, reset, cmd.upd |-> $onehot0(hit))

endmodule

// File: design/hash_set_membership_table_top.sv
// Top level of the hash set membership table: controller plus datapath.
//
//   channel | ports                              | beat
//   --------+------------------------------------+----------------------------
//   request | req_valid, req_ready, req_data     | opcode (2b), key (31b)
//   result  | rsp_valid, rsp_ready, rsp_data     | was_present, dropped
//
// Steps per request: accept, quotient multiply, bucket-count multiply,
//   remainder fix-up, bucket row read, compare and write-back; one request
//   in flight at a time, as the sequencer returns to idle only after write-back.
// Reset: a clearing pass writes empty rows, one bucket a cycle, through all
//   BUCKETS rows; req_ready stays low until it ends.
// Stalls: the result register holds one beat; a new request is taken while it
//   waits, and the write-back step holds until that beat has been taken.
module hash_set_membership_table_top #(
   parameter int unsigned BUCKETS = 769,
   parameter int unsigned WAYS    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hsm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hsm_pkg::rsp_type rsp_data
);

   hsm_pkg::cmd_type    cmd;
   hsm_pkg::status_type status;

   // sequencing and handshakes
   hsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hashing, bucket storage and way compare
   hsm_datapath #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: test/membership_checker.sv
// Checker for the hash set table: predicts every request's answer and compares result beats.
module membership_checker #(
   parameter int unsigned BUCKETS = 769,
   parameter int unsigned WAYS    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hsm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hsm_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               hits_seen,
   output int               drops_seen
);

   localparam int unsigned SLOTS = BUCKETS * WAYS;

   typedef struct {
      logic [hsm_pkg::OP_W-1:0]  opcode;
      logic [hsm_pkg::KEY_W-1:0] key;
      hsm_pkg::rsp_type          answer;
   } awaited_type;

   // shadow of the table
   logic [hsm_pkg::KEY_W-1:0] stored_key [SLOTS];
   bit                        occupied   [SLOTS];
   awaited_type               awaited_answers [$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // Looks the key up in its bucket, applies the opcode, returns the answer.
   function automatic hsm_pkg::rsp_type lookup_and_update(input hsm_pkg::req_type r);
      int unsigned      base;
      int               hit;
      int               spare;
      hsm_pkg::rsp_type res;
      base  = (r.key % BUCKETS) * WAYS;
      hit   = -1;
      spare = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (occupied[base + w]) begin
            if (hit < 0 && stored_key[base + w] == r.key) hit = w;
         end else if (spare < 0) begin
            spare = w;
         end
      end
      res.was_present = (hit >= 0);
      res.dropped     = 1'b0;
      case (r.opcode)
         hsm_pkg::OP_ADD: begin
            if (hit < 0) begin
               if (spare >= 0) begin
                  stored_key[base + spare] = r.key;
                  occupied[base + spare]   = 1'b1;
               end else begin
                  res.dropped = 1'b1;
               end
            end
         end
         hsm_pkg::OP_REMOVE: begin
            if (hit >= 0) occupied[base + hit] = 1'b0;
         end
         default: ;  // query, and the unused code acts as one
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      awaited_type exp_beat;
      if (reset) begin
         foreach (occupied[i]) occupied[i] = 1'b0;
         awaited_answers.delete();
      end else begin
         // result first: it can only belong to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               exp_beat = awaited_answers.pop_front();
               if (rsp_data.was_present !== exp_beat.answer.was_present)
                  report_mismatch($sformatf("op %0d key %0d: was_present %b, expected %b",
                     exp_beat.opcode, exp_beat.key, rsp_data.was_present,
                     exp_beat.answer.was_present));
               if (rsp_data.dropped !== exp_beat.answer.dropped)
                  report_mismatch($sformatf("op %0d key %0d: dropped %b, expected %b",
                     exp_beat.opcode, exp_beat.key, rsp_data.dropped,
                     exp_beat.answer.dropped));
            end
         end
         if (req_valid && req_ready) begin
            exp_beat.opcode = req_data.opcode;
            exp_beat.key    = req_data.key;
            exp_beat.answer = lookup_and_update(req_data);
            if (exp_beat.answer.was_present) hits_seen++;
            if (exp_beat.answer.dropped) drops_seen++;
            awaited_answers.push_back(exp_beat);
         end
      end
      pending <= awaited_answers.size();
   end

endmodule

// File: test/testbench.sv
// Top of the hash set table testbench: clock, reset, request and result traffic, verdict.
module testbench;

   localparam int unsigned BUCKETS = 769;
   localparam int unsigned WAYS    = 4;
   localparam int RANDOM_ITEMS     = 650;
   // largest multiplier k with (BUCKETS-1) + BUCKETS*k still a 31-bit key
   localparam int unsigned MAX_K   = 2792565;
   localparam logic [hsm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_AT_BEAT     = 300;   // receiver hold-off point
   localparam int HOLD_CYCLES      = 250;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   hsm_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   hsm_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int hits_seen;
   int drops_seen;

   // per-opcode tallies of accepted beats, for the closing summary
   int sent_total;
   int sent_by_op [4];
   int directed_count;

   // hot buckets and multipliers: keys b + BUCKETS*k collide in bucket b, so
   // buckets fill, overflow and drain over and over
   int unsigned hot_bucket [6];
   int unsigned hot_k      [8];
   logic [hsm_pkg::KEY_W-1:0] recent_keys [16];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   hash_set_membership_table_top #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   membership_checker #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .hits_seen  (hits_seen),
      .drops_seen (drops_seen)
   );

   // Gap before a beat: drawn at random, but every fourth stretch of 50 beats runs
   // back to back so full-rate traffic is seen too.
   function automatic int draw_gap(input int beat_no);
      if ((beat_no / 50) % 4 == 3) return 0;
      return $urandom_range(0, 11);
   endfunction

   // Offers one request beat and returns at the edge where it is taken.
   // Valid drops only when a gap follows, so it is never lowered and raised
   // in one step.
   task automatic send_request(input logic [hsm_pkg::OP_W-1:0] op,
                               input logic [hsm_pkg::KEY_W-1:0] key);
      int gap;
      gap = draw_gap(sent_total);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.opcode <= op;
      req_data.key    <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      recent_keys[sent_total % 16] = key;
      sent_by_op[op]++;
      sent_total++;
   endtask

   // Sender pause: withdraw valid so the last beat is not offered again, wait
   // for a clock edge so that beat is counted, then until every awaited answer is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [hsm_pkg::KEY_W-1:0] colliding_key(input int unsigned b,
                                                               input int unsigned k);
      int unsigned v;
      v = b + BUCKETS * k;
      return v[hsm_pkg::KEY_W-1:0];
   endfunction

   function automatic logic [hsm_pkg::KEY_W-1:0] pick_key();
      int unsigned roll;
      logic [31:0] raw;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return colliding_key(hot_bucket[$urandom_range(0, 5)], hot_k[$urandom_range(0, 7)]);
      if (roll < 85 && sent_total > 0)
         return recent_keys[$urandom_range(0, 15)];
      raw = $urandom;
      return raw[hsm_pkg::KEY_W-1:0];
   endfunction

   function automatic logic [hsm_pkg::OP_W-1:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return hsm_pkg::OP_ADD;
      if (roll < 65) return hsm_pkg::OP_REMOVE;
      if (roll < 93) return hsm_pkg::OP_QUERY;
      return OP_UNUSED;
   endfunction

   // Receiver: random ready gaps per beat, plus one long hold-off so the
   // result register fills, the block takes one more request and then
   // stalls its input while the sender keeps offering.
   initial begin
      int gap;
      int beats_taken;
      beats_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(beats_taken + 25);
         if (beats_taken == HOLD_AT_BEAT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats_taken++;
      end
   end

   // Hard stop. The slowest correct run spans the clearing pass, about 700 beats
   // with sender and receiver gaps, and the hold-off; the limit below allows many
   // times that.
   initial begin
      #400000;
      $display("Timed out with %0d answers outstanding", pending);
      $display("FAIL");
      $finish;
   end

   initial begin
      hot_bucket[0] = 0;
      hot_bucket[1] = BUCKETS - 1;
      for (int i = 2; i < 6; i++) hot_bucket[i] = $urandom_range(0, BUCKETS - 1);
      hot_k[0] = 0;
      hot_k[1] = MAX_K;
      for (int i = 2; i < 8; i++) hot_k[i] = $urandom_range(0, MAX_K);
      foreach (recent_keys[i]) recent_keys[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty lookups, duplicates, a full bucket, removes of absent
      // keys, refill of a freed slot, the unused opcode, extreme keys.
      send_request(hsm_pkg::OP_QUERY,  31'd0);                   // empty table
      send_request(hsm_pkg::OP_ADD,    31'd0);
      send_request(hsm_pkg::OP_ADD,    31'd0);                   // already present
      send_request(hsm_pkg::OP_ADD,    colliding_key(0, 1));
      send_request(hsm_pkg::OP_ADD,    colliding_key(0, 2));
      send_request(hsm_pkg::OP_ADD,    colliding_key(0, 3));     // bucket 0 now full
      send_request(hsm_pkg::OP_ADD,    colliding_key(0, 4));     // overflow, dropped
      send_request(hsm_pkg::OP_REMOVE, colliding_key(0, 4));     // was never stored
      send_request(hsm_pkg::OP_REMOVE, colliding_key(0, 1));
      send_request(hsm_pkg::OP_REMOVE, colliding_key(0, 1));     // already gone
      send_request(hsm_pkg::OP_ADD,    colliding_key(0, 4));     // lands in freed slot
      send_request(hsm_pkg::OP_QUERY,  colliding_key(0, 4));
      send_request(hsm_pkg::OP_QUERY,  colliding_key(0, 1));
      send_request(OP_UNUSED,          31'd0);                   // behaves as lookup
      send_request(OP_UNUSED,          31'd5);
      send_request(hsm_pkg::OP_ADD,    31'h7fff_ffff);           // largest key
      send_request(hsm_pkg::OP_QUERY,  31'h7fff_ffff);
      send_request(hsm_pkg::OP_REMOVE, 31'h7fff_ffff);
      send_request(hsm_pkg::OP_QUERY,  31'h7fff_ffff);
      send_request(hsm_pkg::OP_ADD,    colliding_key(BUCKETS - 1, 0));   // last bucket
      send_request(hsm_pkg::OP_ADD,    colliding_key(BUCKETS - 1, MAX_K));
      send_request(hsm_pkg::OP_QUERY,  colliding_key(BUCKETS - 1, MAX_K));
      send_request(hsm_pkg::OP_REMOVE, colliding_key(BUCKETS - 1, 0));
      send_request(hsm_pkg::OP_QUERY,  31'd0);
      directed_count = sent_total;
      wait_drained();

      // Random: mostly keys colliding in a few hot buckets, some reuse of
      // recent keys, the rest fully random.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_drained();
         send_request(pick_opcode(), pick_key());
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (12) @(posedge clock);

      $display("Covered %0d beats (%0d directed): %0d add, %0d remove, %0d query, %0d unused.",
               sent_total, directed_count, sent_by_op[hsm_pkg::OP_ADD],
               sent_by_op[hsm_pkg::OP_REMOVE], sent_by_op[hsm_pkg::OP_QUERY],
               sent_by_op[OP_UNUSED]);
      $display("Keys found present %0d times, adds dropped on full buckets %0d, mismatches %0d.",
               hits_seen, drops_seen, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/hsm_pkg.sv
design/hsm_ctrl.sv
design/hsm_datapath.sv
design/hash_set_membership_table_top.sv
test/membership_checker.sv
test/testbench.sv
